/* rtl/tfn_pkg.sv */
// Package for the triangle face normal pipeline.
// Holds the width constants and the word types passed between cells.
// No dependencies.
package tfn_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

	localparam int EDGE_W   = COORD_WIDTH + 1;
	localparam int PROD_W   = 2 * EDGE_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int M_W      = $clog2(CROSS_W + 1);
	localparam int GRP      = 8;
	localparam int NGRP     = (CROSS_W + GRP - 1) / GRP;
	localparam int GL_W     = $clog2(GRP + 1);

	localparam int SCALE_BITS = 30;
	localparam int SQ_W       = 2 * SCALE_BITS;
	localparam int LEN_W      = SQ_W + 2;
	localparam int ROOT_W     = LEN_W / 2;

	localparam int QUO_W = NORMAL_FRAC_BITS + 1;
	localparam int DEN_W = ROOT_W + 1;
	localparam int DIV_W = DEN_W + QUO_W;

	localparam int FRONT_STAGES = 9;

	typedef struct packed {
		logic [2:0][SCALE_BITS-1:0] u;
		logic [2:0]                 neg;
		logic                       degen;
		logic                       last;
	} side_t;

	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [LEN_W-1:0] root;
		logic [LEN_W-1:0] bmask;
		side_t            side;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][DIV_W-1:0] r;
		logic [DIV_W-1:0]      dsh;
		logic [2:0][QUO_W-1:0] q;
		logic [2:0]            neg;
		logic                  degen;
		logic                  last;
	} div_t;

endpackage

/* rtl/tfn_front.sv */
// Front pipeline: edges, cross product, magnitude, bit length, scaling, squared length.
// Depends on tfn_pkg.
module tfn_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 up_ready,
	input  logic signed [2:0][tfn_pkg::COORD_WIDTH-1:0] pa,
	input  logic signed [2:0][tfn_pkg::COORD_WIDTH-1:0] pb,
	input  logic signed [2:0][tfn_pkg::COORD_WIDTH-1:0] pc,
	input  logic                                 last_in,
	input  logic                                 dn_ready,
	output logic                                 out_valid,
	output tfn_pkg::side_t                       side,
	output logic [tfn_pkg::LEN_W-1:0]            len2
);

	localparam int FS = tfn_pkg::FRONT_STAGES;

	logic [FS-1:0] v_q;
	logic [FS:0]   rdy;
	logic [FS-1:0] en;

	logic signed [tfn_pkg::EDGE_W-1:0]  e1_s1 [3];
	logic signed [tfn_pkg::EDGE_W-1:0]  e2_s1 [3];
	logic signed [tfn_pkg::PROD_W-1:0]  p_s2 [6];
	logic signed [tfn_pkg::CROSS_W-1:0] cr_s3 [3];
	logic [tfn_pkg::CROSS_W-1:0]        mag_s4 [3];
	logic [tfn_pkg::CROSS_W-1:0]        mag_s5 [3];
	logic [tfn_pkg::CROSS_W-1:0]        mag_s6 [3];
	logic [tfn_pkg::NGRP-1:0][tfn_pkg::GL_W-1:0] gl_s5;
	logic [tfn_pkg::M_W-1:0]            m_s6;
	logic [2:0][tfn_pkg::SCALE_BITS-1:0] u_s7, u_s8, u_s9;
	logic [tfn_pkg::SQ_W-1:0]           sq_s8 [3];
	logic [tfn_pkg::LEN_W-1:0]          len_s9;
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic       dg_s7, dg_s8, dg_s9;
	logic [FS-1:0] last_q;

	always_comb begin
		rdy[FS] = dn_ready;
		for (int k = FS - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
		for (int k = 0; k < FS; k++) begin
			en[k] = rdy[k] && ((k == 0) ? in_valid : v_q[(k == 0) ? 0 : k - 1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < FS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < FS; k++) begin
			if (en[k]) begin
				last_q[k] <= (k == 0) ? last_in : last_q[(k == 0) ? 0 : k - 1];
			end
		end
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= tfn_pkg::EDGE_W'(signed'(pb[i])) - tfn_pkg::EDGE_W'(signed'(pa[i]));
				e2_s1[i] <= tfn_pkg::EDGE_W'(signed'(pc[i])) - tfn_pkg::EDGE_W'(signed'(pa[i]));
			end
		end
		if (en[1]) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= tfn_pkg::CROSS_W'(p_s2[2*i]) - tfn_pkg::CROSS_W'(p_s2[2*i+1]);
			end
		end
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= cr_s3[i][tfn_pkg::CROSS_W-1];
				mag_s4[i] <= cr_s3[i][tfn_pkg::CROSS_W-1] ? tfn_pkg::CROSS_W'(-cr_s3[i])
				                                          : tfn_pkg::CROSS_W'(cr_s3[i]);
			end
		end
		if (en[4]) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			gl_s5  <= group_len(mag_s4[0] | mag_s4[1] | mag_s4[2]);
		end
		if (en[5]) begin
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			m_s6   <= top_len(gl_s5);
		end
		if (en[6]) begin
			neg_s7 <= neg_s6;
			dg_s7  <= (m_s6 == '0);
			for (int i = 0; i < 3; i++) begin
				if (m_s6 > tfn_pkg::M_W'(tfn_pkg::SCALE_BITS)) begin
					u_s7[i] <= tfn_pkg::SCALE_BITS'(mag_s6[i] >>
					           (m_s6 - tfn_pkg::M_W'(tfn_pkg::SCALE_BITS)));
				end else begin
					u_s7[i] <= tfn_pkg::SCALE_BITS'(mag_s6[i] <<
					           (tfn_pkg::M_W'(tfn_pkg::SCALE_BITS) - m_s6));
				end
			end
		end
		if (en[7]) begin
			neg_s8 <= neg_s7;
			dg_s8  <= dg_s7;
			u_s8   <= u_s7;
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= u_s7[i] * u_s7[i];
			end
		end
		if (en[8]) begin
			neg_s9 <= neg_s8;
			dg_s9  <= dg_s8;
			u_s9   <= u_s8;
			len_s9 <= tfn_pkg::LEN_W'(sq_s8[0]) + tfn_pkg::LEN_W'(sq_s8[1])
			        + tfn_pkg::LEN_W'(sq_s8[2]);
		end
	end

	function automatic logic [tfn_pkg::NGRP-1:0][tfn_pkg::GL_W-1:0] group_len(
		input logic [tfn_pkg::CROSS_W-1:0] w
	);
		logic [tfn_pkg::NGRP*tfn_pkg::GRP-1:0]        pw;
		logic [tfn_pkg::NGRP-1:0][tfn_pkg::GL_W-1:0]  gl;
		pw = (tfn_pkg::NGRP*tfn_pkg::GRP)'(w);
		gl = '0;
		for (int g = 0; g < tfn_pkg::NGRP; g++) begin
			for (int b = 0; b < tfn_pkg::GRP; b++) begin
				if (pw[g*tfn_pkg::GRP+b]) begin
					gl[g] = tfn_pkg::GL_W'(b + 1);
				end
			end
		end
		return gl;
	endfunction

	function automatic logic [tfn_pkg::M_W-1:0] top_len(
		input logic [tfn_pkg::NGRP-1:0][tfn_pkg::GL_W-1:0] gl
	);
		logic [tfn_pkg::M_W-1:0] m;
		m = '0;
		for (int g = 0; g < tfn_pkg::NGRP; g++) begin
			if (gl[g] != '0) begin
				m = tfn_pkg::M_W'(g * tfn_pkg::GRP) + tfn_pkg::M_W'(gl[g]);
			end
		end
		return m;
	endfunction

	assign up_ready   = rdy[0];
	assign out_valid  = v_q[FS-1];
	assign side.u     = u_s9;
	assign side.neg   = neg_s9;
	assign side.degen = dg_s9;
	assign side.last  = last_q[FS-1];
	assign len2       = len_s9;

endmodule

/* rtl/tfn_sqrt_cell.sv */
// One digit step of the integer square root chain.
// Depends on tfn_pkg.
module tfn_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  tfn_pkg::sqrt_t din,
	output logic           up_ready,
	input  logic           dn_ready,
	output logic           out_valid,
	output tfn_pkg::sqrt_t dout
);

	logic             v_q;
	tfn_pkg::sqrt_t   d_q;
	tfn_pkg::sqrt_t   nxt;
	logic [tfn_pkg::LEN_W-1:0] t;

	always_comb begin
		nxt = din;
		t   = din.root + din.bmask;
		if (din.rem >= t) begin
			nxt.rem  = din.rem - t;
			nxt.root = (din.root >> 1) + din.bmask;
		end else begin
			nxt.root = din.root >> 1;
		end
		nxt.bmask = din.bmask >> 2;
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign dout      = d_q;

endmodule

/* rtl/tfn_div_cell.sv */
// One quotient bit step of the three-lane restoring divider chain.
// Depends on tfn_pkg.
module tfn_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tfn_pkg::div_t din,
	output logic          up_ready,
	input  logic          dn_ready,
	output logic          out_valid,
	output tfn_pkg::div_t dout
);

	logic          v_q;
	tfn_pkg::div_t d_q;
	tfn_pkg::div_t nxt;

	always_comb begin
		nxt = din;
		for (int i = 0; i < 3; i++) begin
			if (din.r[i] >= din.dsh) begin
				nxt.r[i] = din.r[i] - din.dsh;
				nxt.q[i] = {din.q[i][tfn_pkg::QUO_W-2:0], 1'b1};
			end else begin
				nxt.q[i] = {din.q[i][tfn_pkg::QUO_W-2:0], 1'b0};
			end
		end
		nxt.dsh = din.dsh >> 1;
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign dout      = d_q;

endmodule

/* rtl/triangle_face_normal.sv */
// Triangle face normal: cross product of the edges scaled to a unit Q2.14 vector.
// Depends on tfn_pkg, tfn_front, tfn_sqrt_cell and tfn_div_cell.
// Pipeline of 9 front stages, 31 square root cells, one divider setup stage,
// 15 divider cells and the output register; one word per cycle when not stalled.
// Every stage holds its own valid bit, so bubbles close up under output stall.
// Reset clears all valid bits asynchronously; the pipeline is empty afterwards.
module triangle_face_normal (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    a_x,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    a_y,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    a_z,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    b_x,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    b_y,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    b_z,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    c_x,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    c_y,
	input  logic signed [tfn_pkg::COORD_WIDTH-1:0]    c_z,
	input  logic                                      last_in,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_x,
	output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_y,
	output logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_z,
	output logic                                      degenerate,
	output logic                                      last_out
);

	localparam int NS = tfn_pkg::ROOT_W;
	localparam int ND = tfn_pkg::QUO_W;

	logic                      fr_up_ready, fr_valid;
	tfn_pkg::side_t            fr_side;
	logic [tfn_pkg::LEN_W-1:0] fr_len2;

	logic                      sq_v [NS+1];
	tfn_pkg::sqrt_t            sq_d [NS+1];
	logic                      sq_r [NS+1];

	logic                      dv_v [ND+1];
	tfn_pkg::div_t             dv_d [ND+1];
	logic                      dv_r [ND+1];

	logic                      prep_v_q;
	tfn_pkg::div_t             prep_q;
	tfn_pkg::div_t             prep_nxt;
	logic [tfn_pkg::ROOT_W-1:0] s_root;

	logic                      out_v_q;
	logic [2:0][tfn_pkg::NORMAL_WIDTH-1:0] nrm_q;
	logic                      dg_q, last_q;
	logic                      out_rdy;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.up_ready  (fr_up_ready),
		.pa        ({a_z, a_y, a_x}),
		.pb        ({b_z, b_y, b_x}),
		.pc        ({c_z, c_y, c_x}),
		.last_in   (last_in),
		.dn_ready  (sq_r[0]),
		.out_valid (fr_valid),
		.side      (fr_side),
		.len2      (fr_len2)
	);

	assign in_stall = !fr_up_ready;

	always_comb begin
		sq_v[0]       = fr_valid;
		sq_d[0].rem   = fr_len2;
		sq_d[0].root  = '0;
		sq_d[0].bmask = tfn_pkg::LEN_W'(1) << (tfn_pkg::LEN_W - 2);
		sq_d[0].side  = fr_side;
	end

	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		tfn_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[g]),
			.din       (sq_d[g]),
			.up_ready  (sq_r[g]),
			.dn_ready  (sq_r[g+1]),
			.out_valid (sq_v[g+1]),
			.dout      (sq_d[g+1])
		);
	end

	assign sq_r[NS] = !prep_v_q || dv_r[0];
	assign s_root   = sq_d[NS].root[tfn_pkg::ROOT_W-1:0];

	always_comb begin
		prep_nxt.dsh   = tfn_pkg::DIV_W'(s_root) << tfn_pkg::QUO_W;
		prep_nxt.q     = '0;
		prep_nxt.neg   = sq_d[NS].side.neg;
		prep_nxt.degen = sq_d[NS].side.degen;
		prep_nxt.last  = sq_d[NS].side.last;
		for (int i = 0; i < 3; i++) begin
			prep_nxt.r[i] = (tfn_pkg::DIV_W'(sq_d[NS].side.u[i]) << (tfn_pkg::NORMAL_FRAC_BITS + 1))
			              + tfn_pkg::DIV_W'(s_root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_q <= 1'b0;
		end else if (sq_r[NS]) begin
			prep_v_q <= sq_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (sq_r[NS] && sq_v[NS]) begin
			prep_q <= prep_nxt;
		end
	end

	assign dv_v[0] = prep_v_q;
	assign dv_d[0] = prep_q;

	for (genvar g = 0; g < ND; g++) begin : g_div
		tfn_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[g]),
			.din       (dv_d[g]),
			.up_ready  (dv_r[g]),
			.dn_ready  (dv_r[g+1]),
			.out_valid (dv_v[g+1]),
			.dout      (dv_d[g+1])
		);
	end

	assign out_rdy  = !out_v_q || !out_stall;
	assign dv_r[ND] = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= dv_v[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && dv_v[ND]) begin
			dg_q   <= dv_d[ND].degen;
			last_q <= dv_d[ND].last;
			for (int i = 0; i < 3; i++) begin
				if (dv_d[ND].degen) begin
					nrm_q[i] <= '0;
				end else if (dv_d[ND].neg[i]) begin
					nrm_q[i] <= tfn_pkg::NORMAL_WIDTH'(-tfn_pkg::NORMAL_WIDTH'(dv_d[ND].q[i]));
				end else begin
					nrm_q[i] <= tfn_pkg::NORMAL_WIDTH'(dv_d[ND].q[i]);
				end
			end
		end
	end

	assign out_valid  = out_v_q;
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign degenerate = dg_q;
	assign last_out   = last_q;

endmodule

/* rtl/tfn_checker.sv */
// Port-level checks on the result channel of triangle_face_normal.
// Depends on tfn_pkg; bound to the top level below.
module tfn_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] normal_x,
	input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] normal_y,
	input logic signed [tfn_pkg::NORMAL_WIDTH-1:0] normal_z,
	input logic                                    degenerate
);

	localparam logic signed [tfn_pkg::NORMAL_WIDTH-1:0] ONE =
		tfn_pkg::NORMAL_WIDTH'(1) << tfn_pkg::NORMAL_FRAC_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normal_x) && $stable(normal_y)
		&& $stable(normal_z) && $stable(degenerate))
		else $error("stalled result word changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate face with nonzero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
		&& normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
		else $error("normal component beyond unit range");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word valid during reset");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);
